@@ src/circular_deque_macros.svh @@
// Assertion macros shared by the circular deque RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular deque check failed (same cycle)");

// Next-cycle implication, disabled while reset is high.
`define CD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular deque check failed (next cycle)");

`endif

@@ src/cd_pkg.sv @@
// Shared constants and types for the circular deque.
// Depends on nothing; used by circular_deque.
`default_nettype none

package cd_pkg;

   // Field widths of the request, response and control register
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int CAP_W   = 5;

   typedef logic [KIND_W-1:0] kind_type;

   // Request kinds
   localparam kind_type KIND_PUSH_BACK  = 3'd0;
   localparam kind_type KIND_PUSH_FRONT = 3'd1;
   localparam kind_type KIND_POP_BACK   = 3'd2;
   localparam kind_type KIND_POP_FRONT  = 3'd3;
   localparam kind_type KIND_PEEK_BACK  = 3'd4;
   localparam kind_type KIND_PEEK_FRONT = 3'd5;
   localparam kind_type KIND_CLEAR      = 3'd6;

   // Build defaults and register reset value
   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

@@ src/circular_deque.sv @@
// Circular deque: double-ended queue in a circular slot store of DEPTH entries.
// Depends on cd_pkg and on circular_deque_macros.svh for its checks.
//
// Usage:
//  - Request beats arrive on req_* (req_tuser = kind, req_tdata = value). Kinds are
//    push back, push front, pop back, pop front, peek back, peek front and clear.
//  - Every request beat yields exactly one response beat on rsp_*: status (1 = a push
//    into a full deque, or a pop or peek on an empty one), the element read (zero when
//    nothing is read), the count after the request and empty and full flags.
//  - csr_wr_en/csr_wr_data write the capacity in use (0 acts as 1, values above DEPTH
//    act as DEPTH). Write it only while idle and issue a clear afterward.
//  - The response is valid in the cycle after its request beat is taken.
//  - Throughput: one request per cycle while the receiver takes responses. The pointer
//    update, the slot write and the slot read all happen on the edge that takes the
//    request; the slot read lands in a registered read port that drives the response data.
//  - When the receiver stalls, the response register holds and req_tready falls; a new
//    request is taken in the same cycle that the waiting response is taken.
//  - Reset clears the pointers, the count and the response valid, and sets the
//    capacity to 16. Slot contents are not cleared; only written slots are ever read.
`default_nettype none
`include "circular_deque_macros.svh"

module circular_deque #(
   parameter int DEPTH = cd_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = cd_pkg::WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Capacity register write port
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   // Request beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] kind
   // Response beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [0] status, [32:1] read_value,
                                         // [37:33] count, [38] is_empty, [39] is_full
);

   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int CMPW = (CNTW > cd_pkg::CAP_W) ? CNTW : cd_pkg::CAP_W;
   localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

   // State
   logic [cd_pkg::CAP_W-1:0] cap_ff;
   logic [IW-1:0]            front_ff, front_in;
   logic [IW-1:0]            back_ff, back_in;
   logic [CNTW-1:0]          count_ff, count_in;
   logic [WIDTH-1:0]         slots_ff [DEPTH];
   logic [WIDTH-1:0]         rd_data_ff;

   // Response register
   logic                     rsp_valid_ff;
   logic                     status_ff, status_in;
   logic                     rd_used_ff, rd_used_in;
   logic [cd_pkg::COUNT_W-1:0] out_count_ff;
   logic                     empty_ff, full_ff;

   logic                     req_acc;
   cd_pkg::kind_type         kind;
   logic [WIDTH-1:0]         push_elem;
   logic [CNTW-1:0]          cap_eff;
   logic [CMPW-1:0]          cap_cmp;
   logic                     is_full_now, is_empty_now;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr, rd_addr;

   // Step an index forward with wraparound at the capacity.
   function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] idx,
                                               input logic [CNTW-1:0] cap);
      logic [CNTW:0] nxt;
      nxt = (CNTW+1)'(idx) + (CNTW+1)'(1);
      return (nxt >= (CNTW+1)'(cap)) ? '0 : IW'(nxt);
   endfunction

   // Step an index backward with wraparound at the capacity.
   function automatic logic [IW-1:0] step_back(input logic [IW-1:0] idx,
                                                input logic [CNTW-1:0] cap);
      logic [CNTW-1:0] top;
      top = cap - CNTW'(1);
      return (idx == '0) ? IW'(top) : idx - IW'(1);
   endfunction

   // Handshake: take a request whenever the response register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign push_elem  = WIDTH'(req_tdata);

   // Effective capacity: zero acts as one, values above DEPTH act as DEPTH.
   assign cap_cmp = CMPW'(cap_ff);
   always_comb begin
      priority if (cap_cmp == '0) begin
         cap_eff = CNTW'(1);
      end else if (cap_cmp > DEPTH_CMP) begin
         cap_eff = CNTW'(DEPTH);
      end else begin
         cap_eff = CNTW'(cap_cmp);
      end
   end

   assign is_full_now  = count_ff >= cap_eff;
   assign is_empty_now = count_ff == '0;

   // Next pointers, count, slot access and status for the offered request.
   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      status_in  = 1'b0;
      rd_used_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = back_ff;
      rd_addr    = front_ff;
      unique case (kind)
         cd_pkg::KIND_PUSH_BACK: begin
            if (is_full_now) begin
               status_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_ff;
               back_in  = step_fwd(back_ff, cap_eff);
               count_in = count_ff + CNTW'(1);
            end
         end
         cd_pkg::KIND_PUSH_FRONT: begin
            if (is_full_now) begin
               status_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               front_in = step_back(front_ff, cap_eff);
               wr_addr  = front_in;
               count_in = count_ff + CNTW'(1);
            end
         end
         cd_pkg::KIND_POP_BACK: begin
            rd_addr = step_back(back_ff, cap_eff);
            if (is_empty_now) begin
               status_in = 1'b1;
            end else begin
               rd_used_in = 1'b1;
               back_in    = rd_addr;
               count_in   = count_ff - CNTW'(1);
            end
         end
         cd_pkg::KIND_POP_FRONT: begin
            rd_addr = front_ff;
            if (is_empty_now) begin
               status_in = 1'b1;
            end else begin
               rd_used_in = 1'b1;
               front_in   = step_fwd(front_ff, cap_eff);
               count_in   = count_ff - CNTW'(1);
            end
         end
         cd_pkg::KIND_PEEK_BACK: begin
            rd_addr = step_back(back_ff, cap_eff);
            if (is_empty_now) begin
               status_in = 1'b1;
            end else begin
               rd_used_in = 1'b1;
            end
         end
         cd_pkg::KIND_PEEK_FRONT: begin
            rd_addr = front_ff;
            if (is_empty_now) begin
               status_in = 1'b1;
            end else begin
               rd_used_in = 1'b1;
            end
         end
         cd_pkg::KIND_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cd_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (req_acc) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Slot store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req_acc && wr_en) begin
         slots_ff[wr_addr] <= push_elem;
      end
      if (req_acc) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         status_ff    <= status_in;
         rd_used_ff   <= rd_used_in;
         out_count_ff <= cd_pkg::COUNT_W'(count_in);
         empty_ff     <= count_in == '0;
         full_ff      <= count_in >= cap_eff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {full_ff, empty_ff, out_count_ff,
                        rd_used_ff ? cd_pkg::VALUE_W'(rd_data_ff) : '0,
                        status_ff};

   // Checks
   `CD_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(DEPTH))
   `CD_ASSERT_NEXT(a_clear_empties, clock, reset, req_acc && kind == cd_pkg::KIND_CLEAR, count_ff == '0 && front_ff == '0 && back_ff == '0)
   `CD_ASSERT_NEXT(a_reject_keeps, clock, reset, req_acc && status_in, $stable(count_ff) && $stable(front_ff) && $stable(back_ff))
   `CD_ASSERT_NEXT(a_rsp_follows, clock, reset, req_acc, rsp_valid_ff)
   `CD_ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_valid_ff, empty_ff == (out_count_ff == '0))

endmodule

`default_nettype wire
